// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level of the serial bus master.
// Depends on nothing; the including module must have clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

// ----- hdl/rtcsm_pkg.sv -----
// Shared types and constants of the three-wire serial bus master.
// Used by rtcsm_step and the top level; depends on nothing.
package rtcsm_pkg;

	// Request command codes.
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Tick that closes an access: 16 bits of two ticks each.
	localparam logic [5:0] LAST_TICK = 6'd32;

	// Command byte framing: bit 7 always set, bit 0 set for a read.
	localparam logic CMD_BYTE_TOP = 1'b1;

	typedef struct packed {
		logic       enable_level;
		logic       clock_level;
		logic [5:0] tick_step;
		logic [7:0] command_shift;
		logic [7:0] data_shift;
		logic       is_read;
		logic [7:0] received_byte;
	} state_t;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       data_out;
		logic       data_drive;
		logic [7:0] read_data;
		logic       done_res;
		logic       busy_res;
	} result_t;

endpackage

// ----- hdl/rtcsm_step.sv -----
// Next-state and pin logic for one request of the serial bus master.
// Pure combinational; depends on rtcsm_pkg.
module rtcsm_step import rtcsm_pkg::*; (
	input  state_t      cur,
	input  logic [1:0]  command,
	input  logic [5:0]  reg_address,
	input  logic [7:0]  write_data,
	input  logic        data_in,
	output state_t      nxt,
	output result_t     res
);

	logic       done;
	logic [3:0] bit_idx;
	logic [5:0] pin_step;
	logic [3:0] pin_bit;

	assign bit_idx = cur.tick_step[4:1];

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if ((command == CMD_READ || command == CMD_WRITE) && !cur.enable_level) begin
			nxt.is_read       = (command == CMD_READ);
			nxt.command_shift = {CMD_BYTE_TOP, reg_address, command == CMD_READ};
			nxt.data_shift    = (command == CMD_READ) ? 8'd0 : write_data;
			nxt.enable_level  = 1'b1;
			nxt.clock_level   = 1'b0;
			nxt.tick_step     = 6'd0;
		end else if (command == CMD_TICK && cur.enable_level) begin
			if (cur.tick_step >= LAST_TICK) begin
				if (cur.is_read)
					nxt.received_byte = cur.data_shift;
				nxt.enable_level = 1'b0;
				nxt.clock_level  = 1'b0;
				nxt.tick_step    = 6'd0;
				done             = 1'b1;
			end else begin
				// odd tick raises the clock and samples read data
				nxt.clock_level = cur.tick_step[0];
				if (cur.tick_step[0] && cur.is_read && bit_idx[3])
					nxt.data_shift[bit_idx[2:0]] = cur.data_shift[bit_idx[2:0]] | data_in;
				nxt.tick_step = cur.tick_step + 6'd1;
			end
		end
	end

	// pin levels follow the tick just taken
	assign pin_step = (nxt.tick_step == 6'd0) ? 6'd0 : nxt.tick_step - 6'd1;
	assign pin_bit  = pin_step[4:1];

	always_comb begin
		res.chip_enable  = nxt.enable_level;
		res.serial_clock = nxt.clock_level;
		res.read_data    = nxt.received_byte;
		res.done_res     = done;
		res.busy_res     = nxt.enable_level;
		if (!nxt.enable_level) begin
			res.data_out   = 1'b0;
			res.data_drive = 1'b1;
		end else if (!pin_bit[3]) begin
			res.data_out   = nxt.command_shift[pin_bit[2:0]];
			res.data_drive = 1'b1;
		end else if (nxt.is_read) begin
			res.data_out   = 1'b0;
			res.data_drive = 1'b0;
		end else begin
			res.data_out   = nxt.data_shift[pin_bit[2:0]];
			res.data_drive = 1'b1;
		end
	end

endmodule

// ----- hdl/three_wire_rtc_serial_master.sv -----
// Top level of the three-wire serial bus master for a real-time-clock chip.
// Depends on rtcsm_pkg, rtcsm_step and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per transfer:
//   a start-read, a start-write or one bus tick. Output channel
//   (out_valid / out_stall) returns exactly one result per request: the
//   pin levels after that request, the last read byte, done and busy.
//   Drive the pins of the chip from the result fields; feed back the data
//   pin level on data_in with every tick request.
// Timing:
//   A request that is taken sits in the input register, is applied to the
//   bus state and lands in the result register once that register is free;
//   out_valid then rises. One request per cycle is sustained while out_stall
//   stays low; the state update is a single pass of narrow logic.
//   A full access is one start plus 33 ticks.
// Stall:
//   While out_stall holds a waiting result, the input register holds its
//   request and in_stall rises once it is full; nothing is lost or repeated.
// Reset:
//   arst_n clears the bus state (enable low, clock low, read byte zero) and
//   empties both registers.
`include "assert_macros.svh"

module three_wire_rtc_serial_master import rtcsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [5:0] reg_address,
	input  logic [7:0] write_data,
	input  logic       data_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       chip_enable,
	output logic       serial_clock,
	output logic       data_out,
	output logic       data_drive,
	output logic [7:0] read_data,
	output logic       done_res,
	output logic       busy_res
);

	// input register
	logic       valid_s1;
	logic [1:0] command_s1;
	logic [5:0] reg_address_s1;
	logic [7:0] write_data_s1;
	logic       data_in_s1;

	// result register
	logic       valid_s2;
	result_t    res_s2;

	// bus state
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;

	logic       out_free;
	logic       advance;
	logic       in_take;

	// result register can take a new result when empty or being drained
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	rtcsm_step u_step (
		.cur         (state_q),
		.command     (command_s1),
		.reg_address (reg_address_s1),
		.write_data  (write_data_s1),
		.data_in     (data_in_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	// hold the input request until it is applied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1     <= command;
			reg_address_s1 <= reg_address;
			write_data_s1  <= write_data;
			data_in_s1     <= data_in;
		end
	end

	// advance the bus state once per applied request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign chip_enable  = res_s2.chip_enable;
	assign serial_clock = res_s2.serial_clock;
	assign data_out     = res_s2.data_out;
	assign data_drive   = res_s2.data_drive;
	assign read_data    = res_s2.read_data;
	assign done_res     = res_s2.done_res;
	assign busy_res     = res_s2.busy_res;

	// an idle bus always restarts from tick zero with clock low
	`ASSERT_CLK(a_idle_clean, !state_q.enable_level |-> (state_q.tick_step == 6'd0 && !state_q.clock_level))
	// the tick counter never passes the closing tick
	`ASSERT_CLK(a_step_range, state_q.tick_step <= LAST_TICK)
	// done only ends an access: enable is low on that result
	`ASSERT_CLK(a_done_drops, (valid_s2 && res_s2.done_res) |-> !res_s2.chip_enable)
	// a released data pin only happens inside an access and drives zero
	`ASSERT_CLK(a_release, (valid_s2 && !res_s2.data_drive) |-> (res_s2.chip_enable && !res_s2.data_out))

endmodule
